>>> rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

   // Screen geometry defaults and fixed field widths
   localparam int COLUMNS_DEFAULT     = 80;
   localparam int ROWS_DEFAULT        = 25;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int KIND_W     = 2;
   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 7;
   localparam int WORD_W     = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   localparam int TAB_WIDTH = 4;

   localparam logic [CHAR_W-1:0] SPACE_CHAR       = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR     = 8'h0A;
   localparam logic [CHAR_W-1:0] TAB_CHAR         = 8'h09;
   localparam logic [ATTR_W-1:0] RESET_BLANK_ATTR = 8'h0F;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   // Classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_PRINT    = 3'd0,
      OP_NEWLINE  = 3'd1,
      OP_TAB      = 3'd2,
      OP_READ     = 3'd3,
      OP_READ_OUT = 3'd4,
      OP_CLEAR    = 3'd5,
      OP_NOP      = 3'd6
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [CHAR_W-1:0] ch;
      logic [ATTR_W-1:0] attr;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } cmd_type;

endpackage

>>> rtl/tcw_front.sv
// Front end: classifies incoming requests and queues them for the back end.
module tcw_front #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT,
   parameter int DEPTH   = tcw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            hold,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tcw_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [tcw_pkg::KIND_W-1:0]      req_tuser,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output tcw_pkg::cmd_type                cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W:0]   CNT_FULL = (PTR_W + 1)'(DEPTH);
   localparam logic [tcw_pkg::ROW_W+1:0] ROW_LIM = (tcw_pkg::ROW_W + 2)'(ROWS);
   localparam logic [tcw_pkg::COL_W:0]   COL_LIM = (tcw_pkg::COL_W + 1)'(COLUMNS);

   tcw_pkg::cmd_type q_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   tcw_pkg::cmd_type             cls;
   logic [tcw_pkg::KIND_W-1:0]   kind;
   logic                         push, pop, in_range;

   assign kind     = req_tuser;
   assign in_range = ({2'b00, req_tdata[20:16]} < ROW_LIM) &&
                     ({1'b0, req_tdata[27:21]} < COL_LIM);

   always_comb begin
      cls.ch   = req_tdata[7:0];
      cls.attr = req_tdata[15:8];
      cls.row  = req_tdata[20:16];
      cls.col  = req_tdata[27:21];
      unique case (kind)
         tcw_pkg::KIND_PUT: begin
            if (cls.ch == tcw_pkg::NEWLINE_CHAR)  cls.op = tcw_pkg::OP_NEWLINE;
            else if (cls.ch == tcw_pkg::TAB_CHAR) cls.op = tcw_pkg::OP_TAB;
            else                                  cls.op = tcw_pkg::OP_PRINT;
         end
         tcw_pkg::KIND_READ:  cls.op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_READ_OUT;
         tcw_pkg::KIND_CLEAR: cls.op = tcw_pkg::OP_CLEAR;
         default:             cls.op = tcw_pkg::OP_NOP;
      endcase
   end

   assign req_tready = (count_ff != CNT_FULL) && !hold;
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != '0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= cls;
   end

endmodule

>>> rtl/tcw_back.sv
// Back end: screen memory, cursor and the fill / scroll sequencer.
module tcw_back #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   input  tcw_pkg::cmd_type                cmd,
   input  logic [tcw_pkg::ATTR_W-1:0]      blank_attr,
   output logic                            init_active,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tcw_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = tcw_pkg::ROW_W;
   localparam int COL_W  = tcw_pkg::COL_W;
   localparam int WORD_W = tcw_pkg::WORD_W;

   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_ADDR = ADDR_W'((ROWS - 1) * COLUMNS);
   localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
   localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);
   localparam logic [COL_W:0]    COL_LIM     = (COL_W + 1)'(COLUMNS);
   localparam logic [COL_W:0]    TAB_W       = (COL_W + 1)'(tcw_pkg::TAB_WIDTH);

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_FILL       = 6'b000010,
      ST_SCROLL     = 6'b000100,
      ST_SCROLL_END = 6'b001000,
      ST_READ       = 6'b010000,
      ST_FINISH     = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      AFTER_IDLE   = 2'd0,
      AFTER_SCROLL = 2'd1,
      AFTER_FINISH = 2'd2
   } after_type;

   logic [WORD_W-1:0] mem [CELLS];
   logic [WORD_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata;

   state_type          state_ff, state_in;
   after_type          after_ff, after_in;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic [ADDR_W-1:0]  end_ff, end_in;
   logic [WORD_W-1:0]  fill_word_ff, fill_word_in;
   logic               wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]  wr_addr_ff, wr_addr_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [WORD_W-1:0]  res_word_ff, res_word_in;
   logic               res_scroll_ff, res_scroll_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [tcw_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0]  row_base, cur_addr, read_addr;
   logic [WORD_W-1:0]  blank_word;
   logic               row_last, col_last, tab_far;

   assign row_base   = ADDR_W'(cur_row_ff) * COLS_A;
   assign cur_addr   = row_base + ADDR_W'(cur_col_ff);
   assign read_addr  = ADDR_W'(cmd.row) * COLS_A + ADDR_W'(cmd.col);
   assign blank_word = {blank_attr, tcw_pkg::SPACE_CHAR};
   assign row_last   = (cur_row_ff == ROW_LAST);
   assign col_last   = (cur_col_ff == COL_LAST);
   assign tab_far    = ({1'b0, cur_col_ff} + TAB_W) >= COL_LIM;

   assign cmd_ready   = (state_ff == ST_IDLE);
   assign init_active = (state_ff == ST_FILL) && (after_ff == AFTER_IDLE);
   assign rsp_tvalid  = rsp_tvalid_ff;
   assign rsp_tdata   = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      after_in      = after_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      fill_word_in  = fill_word_ff;
      wr_pend_in    = wr_pend_ff;
      wr_addr_in    = wr_addr_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      res_word_in   = res_word_ff;
      res_scroll_in = res_scroll_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff;
      mem_wdata     = fill_word_ff;
      mem_raddr     = ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               res_word_in   = '0;
               res_scroll_in = 1'b0;
               case (cmd.op) inside
                  tcw_pkg::OP_PRINT: begin
                     mem_we    = 1'b1;
                     mem_waddr = cur_addr;
                     mem_wdata = {cmd.attr, cmd.ch};
                     state_in  = ST_FINISH;
                     if (col_last) begin
                        cur_col_in = '0;
                        if (row_last) begin
                           res_scroll_in = 1'b1;
                           ptr_in        = COLS_A;
                           wr_pend_in    = 1'b0;
                           state_in      = ST_SCROLL;
                        end else begin
                           cur_row_in = cur_row_ff + 1'b1;
                        end
                     end else begin
                        cur_col_in = cur_col_ff + 1'b1;
                     end
                  end
                  tcw_pkg::OP_NEWLINE, tcw_pkg::OP_TAB: begin
                     ptr_in       = cur_addr;
                     fill_word_in = blank_word;
                     state_in     = ST_FILL;
                     if (cmd.op == tcw_pkg::OP_TAB && !tab_far) begin
                        // tab well inside the row: four blanks
                        end_in     = cur_addr + ADDR_W'(tcw_pkg::TAB_WIDTH - 1);
                        cur_col_in = cur_col_ff + COL_W'(tcw_pkg::TAB_WIDTH);
                        after_in   = AFTER_FINISH;
                     end else begin
                        // blank to end of row, then next row (or scroll on the bottom row)
                        end_in     = row_base + ADDR_W'(COL_LAST);
                        cur_col_in = '0;
                        if (row_last) begin
                           res_scroll_in = 1'b1;
                           after_in      = AFTER_SCROLL;
                        end else begin
                           cur_row_in = cur_row_ff + 1'b1;
                           after_in   = AFTER_FINISH;
                        end
                     end
                  end
                  tcw_pkg::OP_READ: begin
                     mem_raddr = read_addr;
                     state_in  = ST_READ;
                  end
                  tcw_pkg::OP_CLEAR: begin
                     ptr_in       = '0;
                     end_in       = LAST_ADDR;
                     fill_word_in = blank_word;
                     after_in     = AFTER_FINISH;
                     state_in     = ST_FILL;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = fill_word_ff;
            if (ptr_ff == end_ff) begin
               case (after_ff)
                  AFTER_SCROLL: begin
                     ptr_in     = COLS_A;
                     wr_pend_in = 1'b0;
                     state_in   = ST_SCROLL;
                  end
                  AFTER_FINISH: state_in = ST_FINISH;
                  default:      state_in = ST_IDLE;
               endcase
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_SCROLL: begin
            // read row below, write it one row up in the next cycle
            mem_we     = wr_pend_ff;
            mem_waddr  = wr_addr_ff;
            mem_wdata  = rd_data_ff;
            mem_raddr  = ptr_ff;
            wr_pend_in = 1'b1;
            wr_addr_in = ptr_ff - COLS_A;
            if (ptr_ff == LAST_ADDR) state_in = ST_SCROLL_END;
            else                     ptr_in   = ptr_ff + 1'b1;
         end
         ST_SCROLL_END: begin
            mem_we       = 1'b1;
            mem_waddr    = wr_addr_ff;
            mem_wdata    = rd_data_ff;
            wr_pend_in   = 1'b0;
            ptr_in       = BOTTOM_ADDR;
            end_in       = LAST_ADDR;
            fill_word_in = blank_word;
            after_in     = AFTER_FINISH;
            state_in     = ST_FILL;
         end
         ST_READ: begin
            res_word_in = rd_data_ff;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {3'b000, res_scroll_ff, cur_col_ff, cur_row_ff, res_word_ff};
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         after_ff      <= AFTER_IDLE;
         ptr_ff        <= '0;
         end_ff        <= LAST_ADDR;
         fill_word_ff  <= {tcw_pkg::RESET_BLANK_ATTR, tcw_pkg::SPACE_CHAR};
         wr_pend_ff    <= 1'b0;
         cur_row_ff    <= '0;
         cur_col_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         after_ff      <= after_in;
         ptr_ff        <= ptr_in;
         end_ff        <= end_in;
         fill_word_ff  <= fill_word_in;
         wr_pend_ff    <= wr_pend_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff    <= wr_addr_in;
      res_word_ff   <= res_word_in;
      res_scroll_ff <= res_scroll_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

   // cursor never leaves the screen between items
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (ROW_W + 1)'(cur_row_ff) < (ROW_W + 1)'(ROWS) && (COL_W + 1)'(cur_col_ff) < COL_LIM)
      else $error("cursor out of range");

   // scroll writes land exactly one row above the previous read
   a_scroll_addr: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCROLL || state_ff == ST_SCROLL_END) && wr_pend_ff)
      |-> (wr_addr_ff + COLS_A == $past(ptr_ff)))
      else $error("scroll copy address mismatch");

   // fill pointer never runs past its end
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (ptr_ff <= end_ff))
      else $error("fill pointer past end");

   // a finished result waits while the output register is stalled
   a_finish_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_tvalid_ff && !rsp_tready) |=> (state_ff == ST_FINISH))
      else $error("result overwrote stalled response");

endmodule

>>> rtl/text_console_writer_unit.sv
// Top level of the text console writer: config register, front end and back end.
//
// Text screen of COLUMNS x ROWS 16-bit cells (attribute high byte, character
// low byte) with a cursor. Each request transaction yields exactly one response
// transaction carrying the read cell (zero for non-read kinds and off-screen
// reads), the cursor after the request and a scrolled flag. Requests are
// classified and queued (up to QUEUE_DEPTH) by the front end; the back end owns
// the simple dual-port screen RAM and runs one request at a time. A printable
// put writes one cell, an on-screen read reads one cell, a tab inside the row
// blanks TAB_WIDTH cells, a newline or edge tab blanks the rest of the row and
// a clear blanks every cell; an item that scrolls then copies each row one up
// and blanks the bottom row. A request that waits in the queue also waits for
// the ones ahead of it. After reset a clearing pass writes every cell while
// req_tready stays low; csr writes are taken throughout.
// blank_attribute is written through csr_we / csr_wdata and must only change
// while the block is idle.
module text_console_writer_unit #(
   parameter int COLUMNS     = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS        = tcw_pkg::ROWS_DEFAULT,
   parameter int QUEUE_DEPTH = tcw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] char_code, [15:8] attribute, [20:16] cell_row, [27:21] cell_col
   input  logic [tcw_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] kind
   input  logic [tcw_pkg::KIND_W-1:0]      req_tuser,
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] cell_word, [20:16] cursor_row, [27:21] cursor_col, [28] scrolled
   output logic [tcw_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // blank_attribute register write
   input  logic                            csr_we,
   input  logic [tcw_pkg::ATTR_W-1:0]      csr_wdata
);

   logic [tcw_pkg::ATTR_W-1:0] blank_attr_ff, blank_attr_in;

   tcw_pkg::cmd_type cmd;
   logic             cmd_valid;
   logic             cmd_ready;
   logic             init_active;

   // config register: attribute used by every blank written after the reset pass
   assign blank_attr_in = csr_we ? csr_wdata : blank_attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_attr_ff <= tcw_pkg::RESET_BLANK_ATTR;
      end else begin
         blank_attr_ff <= blank_attr_in;
      end
   end

   // front end: classify and queue requests; held off during the reset pass
   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .DEPTH   (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (init_active),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   // back end: screen RAM, cursor, fill and scroll sequencer, response register
   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .blank_attr  (blank_attr_ff),
      .init_active (init_active),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
